[hw/rtl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CH_PAD = 8'h3D;

	localparam int unsigned TOTAL_W = 24;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// decoder queue depth, power of two
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_END_OK  = 2'd1,
		KIND_END_ERR = 2'd2
	} kind_t;

	// work handed from the front to the back for one accepted character
	typedef struct packed {
		logic [2:0][7:0] bytes;   // decoded bytes, index 0 goes out first
		logic [1:0]      nbytes;  // 0..3
		logic            last;    // end result follows the bytes
		logic            err;     // end result reports a format error
	} job_t;

endpackage

[hw/rtl/base64_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder, one character in, decoded bytes and end status out.
// ----------------------------------------------------------------------------
// Input stream s_*: one character per transaction in s_tdata, s_tlast marks
// the last character of a string. Output stream m_*: one result per
// transaction, m_tuser gives its kind (data byte, end ok, end with error),
// m_tdata carries the byte and the saturated running byte count.
// A character is taken every cycle while the job queue has room. Bytes of a
// quartet appear when its fourth character arrives, the end result follows
// them on the last character. The first result of a character passes through the
// job queue and the output register. The output side moves one result per cycle
// while the receiver takes them, so a character that completes a quartet at end
// of string occupies it for up to four results; the four-entry job queue absorbs the difference.
// When the receiver stalls, the output register holds its result, the queue
// fills and s_tready drops. Reset clears the quartet state, the count and
// the queue; no result is pending afterwards.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
	import b64d_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] data_byte, [31:8] decoded_total
	output logic [1:0]  m_tuser    // [1:0] result_kind
);

	logic               q_full;
	logic               push;
	job_t               wr_job;
	logic               pop;
	logic               rd_valid;
	job_t               rd_job;
	kind_t              kind;
	logic [7:0]         data_byte;
	logic [TOTAL_W-1:0] decoded_total;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.text_char   (s_tdata),
		.end_of_text (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.job         (wr_job)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_job   (rd_job)
	);

	b64d_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (rd_valid),
		.job           (rd_job),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.result_kind   (kind),
		.data_byte     (data_byte),
		.decoded_total (decoded_total)
	);

	assign m_tdata = {decoded_total, data_byte};
	assign m_tuser = kind;

endmodule

[hw/rtl/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the quartet and turns characters that yield bytes or end the string into jobs.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_char,
	input  logic       end_of_text,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	logic [1:0]      phase_q, phase_n;
	logic [2:0][5:0] sx_q, sx_n;
	logic            pad3_q, pad3_n;
	logic            inv_q, inv_n;
	logic            padseen_q, padseen_n;
	logic            err_q, err_n;

	logic            accept;
	logic            c_bad;
	logic [5:0]      c_val;
	logic            pad4;
	logic            bad;

	// standard alphabet lookup; anything else is flagged bad
	always_comb begin
		c_bad = 1'b0;
		c_val = 6'd0;
		if (text_char >= 8'h41 && text_char <= 8'h5A) begin
			c_val = 6'(text_char - 8'h41);
		end else if (text_char >= 8'h61 && text_char <= 8'h7A) begin
			c_val = 6'(text_char - 8'h61 + 8'd26);
		end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
			c_val = 6'(text_char - 8'h30 + 8'd52);
		end else if (text_char == 8'h2B) begin
			c_val = 6'h3E;
		end else if (text_char == 8'h2F) begin
			c_val = 6'h3F;
		end else begin
			c_bad = 1'b1;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pad4     = (text_char == CH_PAD);

	always_comb begin
		phase_n   = phase_q;
		sx_n      = sx_q;
		pad3_n    = pad3_q;
		inv_n     = inv_q;
		padseen_n = padseen_q;
		err_n     = err_q;
		bad       = 1'b0;
		job.bytes  = '0;
		job.nbytes = 2'd0;
		job.last   = end_of_text;
		if (phase_q != 2'd3) begin
			if (phase_q == 2'd2 && pad4) begin
				pad3_n   = 1'b1;
				sx_n[2]  = 6'd0;
			end else begin
				inv_n = inv_q | c_bad;
				sx_n[phase_q] = c_bad ? 6'd0 : c_val;
			end
			phase_n = phase_q + 2'd1;
		end else begin
			bad   = inv_q || padseen_q || (!pad4 && (pad3_q || c_bad));
			err_n = err_q | bad;
			job.bytes[0] = {sx_q[0], sx_q[1][5:4]};
			job.bytes[1] = {sx_q[1][3:0], sx_q[2][5:2]};
			job.bytes[2] = {sx_q[2][1:0], c_val};
			if (!err_n) begin
				job.nbytes = pad4 ? (pad3_q ? 2'd1 : 2'd2) : 2'd3;
			end
			padseen_n = padseen_q | pad4;
			phase_n   = 2'd0;
			sx_n      = '0;
			pad3_n    = 1'b0;
			inv_n     = 1'b0;
		end
		job.err = err_n;
		if (end_of_text) begin
			phase_n   = 2'd0;
			sx_n      = '0;
			pad3_n    = 1'b0;
			inv_n     = 1'b0;
			padseen_n = 1'b0;
			err_n     = 1'b0;
		end
	end

	assign push = accept && (job.nbytes != 2'd0 || end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			sx_q      <= '0;
			pad3_q    <= 1'b0;
			inv_q     <= 1'b0;
			padseen_q <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			sx_q      <= sx_n;
			pad3_q    <= pad3_n;
			inv_q     <= inv_n;
			padseen_q <= padseen_n;
			err_q     <= err_n;
		end
	end

endmodule

[hw/rtl/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue
	import b64d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output job_t rd_job
);

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rp_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Expands jobs into result transactions, keeps the byte count, output register.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  job_t                 job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kind_t                result_kind,
	output logic [7:0]           data_byte,
	output logic [TOTAL_W-1:0]   decoded_total
);

	localparam int unsigned EW = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [1:0]             idx_q;
	logic                   vld_q;
	kind_t                  kind_q;
	logic [7:0]             byte_q;
	logic [TOTAL_W-1:0]     total_q;

	logic                   load;
	logic                   is_byte;
	logic                   job_done;
	logic [EW-1:0]          cnt_ext;
	logic [TOTAL_W-1:0]     total_n;
	kind_t                  kind_n;

	assign load    = job_valid && (!vld_q || out_ready);
	assign is_byte = (idx_q < job.nbytes);
	assign job_done = is_byte ? (!job.last && idx_q == job.nbytes - 2'd1) : 1'b1;
	assign pop     = load && job_done;

	always_comb begin
		cnt_n = cnt_q;
		if (is_byte && cnt_q != CNT_MAX) begin
			cnt_n = cnt_q + 1'b1;
		end
	end

	assign cnt_ext = EW'(cnt_n);
	assign total_n = (cnt_ext > EW'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_W-1:0];
	assign kind_n  = is_byte ? KIND_DATA : (job.err ? KIND_END_ERR : KIND_END_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
			cnt_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= job_done ? 2'd0 : idx_q + 2'd1;
				// end of string starts the next one from zero
				cnt_q <= is_byte ? cnt_n : '0;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_n;
			byte_q  <= is_byte ? job.bytes[idx_q] : 8'd0;
			total_q <= total_n;
		end
	end

	assign out_valid     = vld_q;
	assign result_kind   = kind_q;
	assign data_byte     = byte_q;
	assign decoded_total = total_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_stream_decoder_top. Characters are streamed
// in with random idling on both sides. Each accepted character goes through a
// local decoder model, and every result on the output stream is compared
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
	import b64d_pkg::*;

	localparam int unsigned COUNT_W    = TOTAL_W;
	localparam logic [7:0]  NOT_B64    = 8'hFF;
	localparam int unsigned HOLD_LEN   = 80;
	localparam int unsigned WDOG_LIMIT = 2000;

	typedef enum logic [1:0] {
		PACE_RX_SLOW = 2'd0,   // sender idles 27%, receiver 53%
		PACE_TX_SLOW = 2'd1,   // sender idles 53%, receiver 27%
		PACE_FULL    = 2'd2    // no idling
	} pace_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		pace_t      pace;
		logic       drain;   // wait for all results before offering
		logic       hold;    // receiver stalls for a long stretch
	} char_item_t;

	typedef struct {
		kind_t        kind;
		logic [7:0]   dbyte;
		logic [23:0]  total;
	} dec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	char_item_t  pending[$];
	dec_result_t expected_results[$];

	// decoder model state
	logic [1:0]         q_phase = '0;
	logic [5:0]         q_sx [3] = '{default: '0};
	logic               q_pad3 = 1'b0;
	logic               q_inval = 1'b0;
	logic               q_padded = 1'b0;
	logic               q_err = 1'b0;
	logic [COUNT_W-1:0] q_total = '0;

	pace_t       cur_pace = PACE_RX_SLOW;
	logic        mark_drain = 1'b0;
	logic        mark_hold = 1'b0;
	pace_t       rx_pace = PACE_RX_SLOW;
	int unsigned hold_seq = 0;

	int unsigned errors = 0;
	int unsigned strings_made = 0;
	int unsigned chars_in = 0;
	int unsigned bytes_out = 0;
	int unsigned ends_ok = 0;
	int unsigned ends_err = 0;
	int unsigned idle_cycles = 0;

	base64_stream_decoder_top #(.COUNT_WIDTH(COUNT_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] sextet_val(logic [7:0] c);
		if (c >= "A" && c <= "Z") return c - "A";
		if (c >= "a" && c <= "z") return c - "a" + 8'd26;
		if (c >= "0" && c <= "9") return c - "0" + 8'd52;
		if (c == "+") return 8'h3E;
		if (c == "/") return 8'h3F;
		return NOT_B64;
	endfunction

	function automatic int unsigned idle_pct(pace_t pace, bit rx);
		case (pace)
			PACE_RX_SLOW: return rx ? 53 : 27;
			PACE_TX_SLOW: return rx ? 27 : 53;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] rand_b64();
		int unsigned k;
		k = $urandom_range(0, 63);
		if (k < 26) return "A" + 8'(k);
		if (k < 52) return "a" + 8'(k - 26);
		if (k < 62) return "0" + 8'(k - 52);
		return (k == 62) ? "+" : "/";
	endfunction

	task automatic push_byte(logic [7:0] b);
		dec_result_t r;
		if (q_total != '1) q_total++;
		r.kind  = KIND_DATA;
		r.dbyte = b;
		r.total = q_total;
		expected_results.push_back(r);
	endtask

	task automatic decode_char(logic [7:0] c, logic last);
		logic [7:0]  s;
		logic        pad4;
		logic        bad;
		dec_result_t r;
		s = sextet_val(c);
		if (q_phase != 2'd3) begin
			if (q_phase == 2'd2 && c == CH_PAD) begin
				q_pad3 = 1'b1;
				q_sx[2] = '0;
			end else begin
				if (s == NOT_B64) q_inval = 1'b1;
				q_sx[q_phase] = (s == NOT_B64) ? 6'd0 : s[5:0];
			end
			q_phase++;
		end else begin
			pad4 = (c == CH_PAD);
			bad = q_inval || q_padded;
			if (!pad4) bad = bad || q_pad3 || (s == NOT_B64);
			if (bad) q_err = 1'b1;
			if (!q_err) begin
				push_byte({q_sx[0], q_sx[1][5:4]});
				if (!(pad4 && q_pad3)) push_byte({q_sx[1][3:0], q_sx[2][5:2]});
				if (!pad4) push_byte({q_sx[2][1:0], s[5:0]});
			end
			if (pad4) q_padded = 1'b1;
			q_phase = '0;
			q_sx = '{default: '0};
			q_pad3 = 1'b0;
			q_inval = 1'b0;
		end
		if (last) begin
			r.kind  = q_err ? KIND_END_ERR : KIND_END_OK;
			r.dbyte = '0;
			r.total = q_total;
			expected_results.push_back(r);
			q_phase = '0;
			q_sx = '{default: '0};
			q_pad3 = 1'b0;
			q_inval = 1'b0;
			q_padded = 1'b0;
			q_err = 1'b0;
			q_total = '0;
		end
	endtask

	task automatic add_char(logic [7:0] c, logic last);
		char_item_t it;
		it.ch    = c;
		it.last  = last;
		it.pace  = cur_pace;
		it.drain = mark_drain;
		it.hold  = mark_hold;
		mark_drain = 1'b0;
		mark_hold = 1'b0;
		pending.push_back(it);
	endtask

	task automatic add_text(string t, logic last);
		for (int i = 0; i < t.len(); i++)
			add_char(t[i], last && (i == t.len() - 1));
	endtask

	// mostly well-formed strings, some corrupted, some pure noise
	task automatic gen_string();
		logic [7:0]  chars[$];
		int unsigned tail;
		if ($urandom_range(0, 9) < 7) begin
			repeat ($urandom_range(0, 4) * 4) chars.push_back(rand_b64());
			tail = $urandom_range(0, 2);
			if (tail == 1) begin
				repeat (2) chars.push_back(rand_b64());
				repeat (2) chars.push_back(CH_PAD);
			end else if (tail == 2) begin
				repeat (3) chars.push_back(rand_b64());
				chars.push_back(CH_PAD);
			end
			// data after padding
			if (tail != 0 && $urandom_range(0, 9) == 0)
				repeat (4) chars.push_back(rand_b64());
			// trailing partial quartet
			repeat ($urandom_range(0, 3))
				chars.push_back($urandom_range(0, 1) ? rand_b64() : 8'($urandom_range(0, 255)));
			if (chars.size() != 0 && $urandom_range(0, 6) == 0)
				chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(1, 12))
				case ($urandom_range(0, 2))
					0: chars.push_back(8'($urandom_range(0, 255)));
					1: chars.push_back(CH_PAD);
					default: chars.push_back(rand_b64());
				endcase
		end
		if (chars.size() == 0) chars.push_back(rand_b64());
		foreach (chars[i]) add_char(chars[i], i == chars.size() - 1);
		strings_made++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : char_driver
		char_item_t nxt;
		logic       offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_char(s_tdata, s_tlast);
				chars_in++;
			end
			if (!s_tvalid || s_tready) begin
				offer = 1'b0;
				if (pending.size() != 0) begin
					nxt = pending[0];
					offer = !(nxt.drain && expected_results.size() != 0) &&
						($urandom_range(0, 99) >= idle_pct(nxt.pace, 1'b0));
				end
				if (offer) begin
					void'(pending.pop_front());
					s_tdata <= nxt.ch;
					s_tlast <= nxt.last;
					rx_pace <= nxt.pace;
					if (nxt.hold) hold_seq <= hold_seq + 1;
				end
				s_tvalid <= offer;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int unsigned hold_seen;
		int unsigned hold_left;
		dec_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				case (m_tuser)
					KIND_DATA: bytes_out++;
					KIND_END_OK: ends_ok++;
					default: ends_err++;
				endcase
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: kind %0d byte %02h total %0d",
						$time, m_tuser, m_tdata[7:0], m_tdata[31:8]);
				end else begin
					e = expected_results.pop_front();
					if (m_tuser !== e.kind || m_tdata[7:0] !== e.dbyte ||
						m_tdata[31:8] !== e.total) begin
						errors++;
						$display("%0t: expected kind %0d byte %02h total %0d, got kind %0d byte %02h total %0d",
							$time, e.kind, e.dbyte, e.total,
							m_tuser, m_tdata[7:0], m_tdata[31:8]);
					end
				end
			end
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= idle_pct(rx_pace, 1'b1));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, WDOG_LIMIT, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		cur_pace = PACE_RX_SLOW;
		// full and two-pad quartets, then data after padding
		add_text("+/9zTQ==TWFu", 1'b1);
		// trailing partial quartet holding a NUL is ignored
		add_text("TWE=", 1'b0);
		add_char(8'h00, 1'b1);
		// pad in first position and pad followed by data
		add_text("=A=z", 1'b1);
		// character just past the alphabet range
		add_text("Zm9", 1'b0);
		add_char(8'h7B, 1'b1);

		mark_hold = 1'b1;
		while (pending.size() < 100) gen_string();
		cur_pace = PACE_TX_SLOW;
		mark_drain = 1'b1;
		while (pending.size() < 175) gen_string();
		cur_pace = PACE_FULL;
		mark_drain = 1'b1;
		while (pending.size() < 210) gen_string();
		mark_hold = 1'b1;
		while (pending.size() < 248) gen_string();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("run covered %0d strings, %0d characters in", strings_made, chars_in);
		$display("results out: %0d bytes, %0d clean ends, %0d error ends",
			bytes_out, ends_ok, ends_err);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
